FILE: sv/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg: shared types and codes for the small integer arithmetic unit
// Opcodes, status codes, shared-unit command kinds and the control and
// status structs passed between the sequencer and the shared unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sia_pkg;

    localparam int OPC_W  = 3;
    localparam int STAT_W = 2;

    // Operation codes carried in the input tuser.
    localparam logic [OPC_W-1:0] OP_ADD = 3'd0;
    localparam logic [OPC_W-1:0] OP_SUB = 3'd1;
    localparam logic [OPC_W-1:0] OP_MUL = 3'd2;
    localparam logic [OPC_W-1:0] OP_DIV = 3'd3;
    localparam logic [OPC_W-1:0] OP_GCD = 3'd4;

    // Status codes carried in the output tuser.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DIVZERO = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVF     = 2'd2;

    // Work kinds of the shared unit.
    localparam logic [1:0] KIND_ADDSUB = 2'd0;
    localparam logic [1:0] KIND_MUL    = 2'd1;
    localparam logic [1:0] KIND_DIV    = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] kind;
        logic       sub;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

FILE: sv/sia_shared_unit.sv
// ----------------------------------------------------------------------------
// sia_shared_unit: iterative add, multiply and divide engine
// One WIDTH+1 bit adder serves a single-step add or subtract, a shift-add
// multiply and a restoring divide, one bit per cycle for the latter two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sia_shared_unit #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sia_pkg::t_unit_ctl   i_ctl,
    input  logic [WIDTH-1:0]     i_x,
    input  logic [WIDTH-1:0]     i_y,
    output sia_pkg::t_unit_sts   o_sts,
    output logic [WIDTH-1:0]     o_hi,
    output logic [WIDTH-1:0]     o_lo
);
    import sia_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [1:0]       r_kind;
    logic             r_sub;
    logic [WIDTH-1:0] r_opnd;
    logic [WIDTH-1:0] r_hi, n_hi;
    logic [WIDTH-1:0] r_lo, n_lo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   w_add_a;
    logic [WIDTH:0]   w_add_b;
    logic [WIDTH:0]   w_add_b_eff;
    logic             w_sub_eff;
    logic [WIDTH+1:0] w_sum;
    logic             w_ge;

    // The one shared adder. A subtract adds the inverted operand plus one,
    // so the top bit of the sum is set exactly when a >= b.
    always_comb begin
        w_add_a = {1'b0, r_hi};
        w_add_b = {1'b0, r_opnd};
        if (r_kind == KIND_DIV) begin
            w_add_a = {r_hi, r_lo[WIDTH-1]};
        end
        w_sub_eff   = (r_kind == KIND_DIV) | r_sub;
        w_add_b_eff = w_sub_eff ? ~w_add_b : w_add_b;
        w_sum       = {1'b0, w_add_a} + {1'b0, w_add_b_eff} + (WIDTH+2)'(w_sub_eff);
        w_ge        = w_sum[WIDTH+1];
    end

    always_comb begin
        n_hi = r_hi;
        n_lo = r_lo;
        unique case (r_kind)
            KIND_ADDSUB: begin
                n_hi = w_sum[WIDTH-1:0];
            end
            KIND_MUL: begin
                if (r_lo[0]) begin
                    n_hi = w_sum[WIDTH:1];
                    n_lo = {w_sum[0], r_lo[WIDTH-1:1]};
                end else begin
                    n_hi = {1'b0, r_hi[WIDTH-1:1]};
                    n_lo = {r_hi[0], r_lo[WIDTH-1:1]};
                end
            end
            KIND_DIV: begin
                n_hi = w_ge ? w_sum[WIDTH-1:0] : {r_hi[WIDTH-2:0], r_lo[WIDTH-1]};
                n_lo = {r_lo[WIDTH-2:0], w_ge};
            end
            default: begin
                n_hi = r_hi;
                n_lo = r_lo;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_kind <= i_ctl.kind;
            r_sub  <= i_ctl.sub;
            unique case (i_ctl.kind)
                KIND_MUL: begin
                    r_hi   <= '0;
                    r_lo   <= i_y;
                    r_opnd <= i_x;
                end
                KIND_DIV: begin
                    r_hi   <= '0;
                    r_lo   <= i_x;
                    r_opnd <= i_y;
                end
                default: begin
                    r_hi   <= i_x;
                    r_lo   <= i_y;
                    r_opnd <= i_y;
                end
            endcase
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_ctl.kind == KIND_ADDSUB) ? CW'(1) : CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_hi       = r_hi;
    assign o_lo       = r_lo;

endmodule

FILE: sv/small_integer_arith_unit.sv
// ----------------------------------------------------------------------------
// small_integer_arith_unit: signed add, subtract, multiply, divide and gcd
// Add, subtract, multiply and divide each make one pass through the shared
// unit (a divide by zero skips it); gcd makes one divide per Euclid step.
// Throughput: one item at a time; the next input transfer is taken the
// cycle after the result is loaded. Synchronous active-low reset empties it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block takes one transfer on the input stream, works on it with a
// single shared adder (see sia_shared_unit) and presents one transfer on
// the output stream. Multiply and divide work one operand bit per cycle,
// so their time is set by WIDTH. The gcd runs Euclid's loop, issuing one
// divide per remainder step; the number of steps depends on the operands
// (at most a few dozen at WIDTH = 32).
//
// A finished result sits in the output register. A new input transfer
// may be accepted while that result still waits to be taken; the next
// result only stalls in its final state until the register frees up.

module small_integer_arith_unit #(
    parameter int WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, from bit 0 up: operand_a, operand_b, zero fill to whole bytes.
    input  logic [((2*WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    // tuser: opcode.
    input  logic [sia_pkg::OPC_W-1:0]            s_axis_tuser,
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata, from bit 0 up: result_value, zero fill to whole bytes.
    output logic [((WIDTH+7)/8)*8-1:0]           m_axis_tdata,
    // tuser: status.
    output logic [sia_pkg::STAT_W-1:0]           m_axis_tuser
);
    import sia_pkg::*;

    localparam int OUT_DW = ((WIDTH + 7) / 8) * 8;

    localparam logic [WIDTH-1:0] SGN    = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MAXPOS = {1'b0, {(WIDTH-1){1'b1}}};

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_GCHK = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [OPC_W-1:0]  r_op;
    logic [WIDTH-1:0]  r_a;
    logic [WIDTH-1:0]  r_b;
    logic [WIDTH-1:0]  r_gx, n_gx;
    logic [WIDTH-1:0]  r_gy, n_gy;
    logic [WIDTH-1:0]  r_res;
    logic [STAT_W-1:0] r_stat;
    logic              r_m_valid;

    t_unit_ctl         w_ctl;
    t_unit_sts         w_sts;
    logic [WIDTH-1:0]  w_ux, w_uy;
    logic [WIDTH-1:0]  w_hi, w_lo;

    logic [WIDTH-1:0]  w_mag_a, w_mag_b;
    logic              w_neg;
    logic [WIDTH-1:0]  w_neg_lo;
    logic [WIDTH-1:0]  w_fin_res;
    logic [STAT_W-1:0] w_fin_stat;
    logic              w_accept;
    logic              w_load_out;

    sia_shared_unit #(
        .WIDTH (WIDTH)
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (w_ux),
        .i_y     (w_uy),
        .o_sts   (w_sts),
        .o_hi    (w_hi),
        .o_lo    (w_lo)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Magnitudes of the operands. The most negative value maps to
    // 2^(WIDTH-1), which still fits WIDTH unsigned bits.
    assign w_mag_a  = r_a[WIDTH-1] ? ('0 - r_a) : r_a;
    assign w_mag_b  = r_b[WIDTH-1] ? ('0 - r_b) : r_b;
    assign w_neg    = r_a[WIDTH-1] ^ r_b[WIDTH-1];
    assign w_neg_lo = '0 - w_lo;

    // Sequencer: dispatch the work to the shared unit, loop for gcd.
    always_comb begin
        n_state    = r_state;
        n_gx       = r_gx;
        n_gy       = r_gy;
        w_ctl      = '0;
        w_ux       = w_mag_a;
        w_uy       = w_mag_b;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        w_ctl.start = 1'b1;
                        w_ctl.kind  = KIND_ADDSUB;
                        w_ctl.sub   = (r_op == OP_SUB);
                        w_ux        = r_a;
                        w_uy        = r_b;
                        n_state     = S_RUN;
                    end
                    OP_MUL: begin
                        w_ctl.start = 1'b1;
                        w_ctl.kind  = KIND_MUL;
                        n_state     = S_RUN;
                    end
                    OP_DIV: begin
                        if (r_b == '0) begin
                            n_state = S_FIN;
                        end else begin
                            w_ctl.start = 1'b1;
                            w_ctl.kind  = KIND_DIV;
                            n_state     = S_RUN;
                        end
                    end
                    OP_GCD: begin
                        n_gx    = w_mag_a;
                        n_gy    = w_mag_b;
                        n_state = S_GCHK;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_RUN: begin
                if (w_sts.done) begin
                    if (r_op == OP_GCD) begin
                        // Euclid step: (x, y) becomes (y, x mod y).
                        n_gx    = r_gy;
                        n_gy    = w_hi;
                        n_state = S_GCHK;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_GCHK: begin
                if (r_gy == '0) begin
                    n_state = S_FIN;
                end else begin
                    w_ctl.start = 1'b1;
                    w_ctl.kind  = KIND_DIV;
                    w_ux        = r_gx;
                    w_uy        = r_gy;
                    n_state     = S_RUN;
                end
            end
            S_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Final result and status from the unit's registers.
    always_comb begin
        w_fin_res  = '0;
        w_fin_stat = STAT_OK;
        unique case (r_op)
            OP_ADD: begin
                w_fin_res = w_hi;
                if ((~(r_a[WIDTH-1] ^ r_b[WIDTH-1])) & (r_a[WIDTH-1] ^ w_hi[WIDTH-1])) begin
                    w_fin_stat = STAT_OVF;
                end
            end
            OP_SUB: begin
                w_fin_res = w_hi;
                if ((r_a[WIDTH-1] ^ r_b[WIDTH-1]) & (r_a[WIDTH-1] ^ w_hi[WIDTH-1])) begin
                    w_fin_stat = STAT_OVF;
                end
            end
            OP_MUL: begin
                // Product magnitude is {w_hi, w_lo}.
                w_fin_res = w_neg ? w_neg_lo : w_lo;
                if ((w_hi != '0) || (w_lo > (w_neg ? SGN : MAXPOS))) begin
                    w_fin_stat = STAT_OVF;
                end
            end
            OP_DIV: begin
                if (r_b == '0) begin
                    w_fin_stat = STAT_DIVZERO;
                end else begin
                    // Quotient magnitude is in w_lo.
                    w_fin_res = w_neg ? w_neg_lo : w_lo;
                    if (!w_neg && w_lo[WIDTH-1]) begin
                        w_fin_stat = STAT_OVF;
                    end
                end
            end
            OP_GCD: begin
                w_fin_res = r_gx;
                if (r_gx[WIDTH-1]) begin
                    w_fin_stat = STAT_OVF;
                end
            end
            default: begin
                w_fin_res  = '0;
                w_fin_stat = STAT_OK;
            end
        endcase
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= s_axis_tuser;
            r_a  <= s_axis_tdata[WIDTH-1:0];
            r_b  <= s_axis_tdata[2*WIDTH-1:WIDTH];
        end
        r_gx <= n_gx;
        r_gy <= n_gy;
        if (w_load_out) begin
            r_res  <= w_fin_res;
            r_stat <= w_fin_stat;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_DW'(r_res);
    assign m_axis_tuser  = r_stat;

    // The shared unit is never working while a new item may come in.
    a_idle_unit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_sts.busy)
        else $error("shared unit busy while input is ready");

    // The unit only reports completion while the sequencer waits for it.
    a_done_in_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == S_RUN))
        else $error("shared unit completion outside the run state");

    // A divide by zero always returns a zero result.
    a_divzero_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == STAT_DIVZERO)) |-> (r_res == '0))
        else $error("divide-by-zero status with a nonzero result");

endmodule
